// File: rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("port property violated");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("port property violated");

`endif

// File: rtl/pmrc_pkg.sv
package pmrc_pkg;

  // Width of the tick counters; any value from 8 to 32 works.
  localparam int unsigned TIME_BITS = 32;
  localparam int unsigned DUR_W     = 32;
  localparam int unsigned VAL_W     = 11;
  localparam int unsigned LVL_W     = 8;
  localparam int unsigned PCT_W     = 7;
  // Magnitude of target minus start never exceeds 1279, so 11 bits.
  localparam int unsigned DIFF_W    = 11;
  localparam int unsigned DIV_W     = TIME_BITS + DIFF_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_W);
  localparam int unsigned IN_BITS   = VAL_W + DUR_W + 1;
  localparam int unsigned IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_BITS  = LVL_W + 1 + PCT_W + 1 + 1;
  localparam int unsigned OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [2:0] {
    REQ_SET_LEVEL = 3'd0,
    REQ_SET_PCT   = 3'd1,
    REQ_ON        = 3'd2,
    REQ_OFF       = 3'd3,
    REQ_TIMED_ON  = 3'd4,
    REQ_RAMP      = 3'd5,
    REQ_RAMP_PCT  = 3'd6,
    REQ_TICK      = 3'd7
  } req_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_LOAD,
    ST_DIV,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic done;
    logic rem_nz;
  } div_stat_t;

  // trunc(mag*255/100) through a reciprocal multiply with one correction step.
  function automatic logic [11:0] pct_to_lvl(input logic [10:0] mag);
    logic [17:0] x;
    logic [41:0] p;
    logic [11:0] q;
    logic [17:0] r;
    x = 18'(mag) * 18'd255;
    p = 42'(x) * 42'd167772;
    q = p[35:24];
    r = x - 18'(q) * 18'd100;
    if (r >= 18'd100) begin
      q = q + 12'd1;
    end
    return q;
  endfunction

  // floor(lvl*100/255), same scheme.
  function automatic logic [6:0] lvl_to_pct(input logic [7:0] lvl);
    logic [14:0] x;
    logic [23:0] p;
    logic [6:0]  q;
    logic [14:0] r;
    x = 15'(lvl) * 15'd100;
    p = 24'(x) * 24'd257;
    q = p[22:16];
    r = x - 15'(q) * 15'd255;
    if (r >= 15'd255) begin
      q = q + 7'd1;
    end
    return q;
  endfunction

endpackage

// File: rtl/pwm_motor_ramp_controller_unit.sv
// PWM level controller for one motor with timed-on and linear ramps.
// The slave stream carries one command transaction at a time: tuser holds
// the command code, tdata holds the level or percent, the duration in ticks
// and the stop flag. Tick commands advance a running timed-on or ramp.
// Every accepted transaction yields exactly one result transaction on the
// master stream with the level, motor-on flag, percent and mode flags as
// they stand after the command.
// Commands other than a ramp tick go straight to the done state, which
// loads the result register once it is free, and the block is then
// ready again. A tick during a ramp instead computes the new level as
// start + floor(elapsed*(target-start)/span): the multiply state forms
// the product, the load state starts the restoring divider, which makes
// one quotient bit per cycle over 43 bits, and the done state registers
// the result once the divider has finished.
// The block takes one command at a time; tready is high only while idle.
// The result sits in an output register, so a new command is accepted
// while the previous result still waits; a later result then waits in
// its final state until the receiver frees the register.
// Reset clears the level, the ramp and timed-on state and any result.
module pwm_motor_ramp_controller_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [10:0] level_value, [42:11] duration_ms, [43] stop_all, rest zero
  input  logic [pmrc_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // [2:0] req_type
  input  logic [2:0]                          s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [7:0] pwm_level, [8] motor_on, [15:9] pwm_percent, [16] ramp_active,
  // [17] timed_active, rest zero
  output logic [pmrc_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

  pmrc_pkg::state_e state_q, state_d;

  logic [7:0]              level_q, level_d;
  logic [7:0]              start_q, start_d;
  logic signed [10:0]      target_q, target_d;
  logic [pmrc_pkg::TIME_BITS-1:0] elapsed_q, elapsed_d;
  logic [pmrc_pkg::TIME_BITS-1:0] span_q, span_d;
  logic                    ramping_q, ramping_d;
  logic                    timing_q, timing_d;
  logic [pmrc_pkg::DIV_W-1:0] prod_q;
  logic                    neg_q;
  logic                    out_valid_q, out_valid_d;
  logic [pmrc_pkg::OUT_DATA_W-1:0] out_data_q, out_data_d;

  logic                    in_fire;
  logic                    out_free;
  logic                    div_start;
  pmrc_pkg::req_e          req;
  logic signed [10:0]      val;
  logic [pmrc_pkg::TIME_BITS-1:0] dur;
  logic                    stop;
  logic [10:0]             val_mag;
  logic [11:0]             pct_lvl;
  logic signed [10:0]      pct_tgt;
  logic signed [10:0]      ramp_tgt;
  logic [pmrc_pkg::TIME_BITS-1:0] elapsed_inc;
  logic                    ramp_step;
  logic signed [11:0]      diff;
  logic [10:0]             diff_mag;
  pmrc_pkg::div_stat_t     div_stat;
  logic [pmrc_pkg::DIV_W-1:0] div_quo;
  logic [11:0]             step_mag;
  logic signed [12:0]      step_lvl;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  assign req  = pmrc_pkg::req_e'(s_axis_tuser);
  assign val  = $signed(s_axis_tdata[10:0]);
  assign dur  = s_axis_tdata[11 +: pmrc_pkg::TIME_BITS];
  assign stop = s_axis_tdata[pmrc_pkg::VAL_W + pmrc_pkg::DUR_W];

  // Percent conversion truncates toward zero, so work on the magnitude.
  assign val_mag = val[10] ? 11'(-val) : 11'(val);
  assign pct_lvl = pmrc_pkg::pct_to_lvl(val_mag);

  always_comb begin
    if (!val[10]) begin
      pct_tgt = (pct_lvl > 12'd1023) ? 11'sd1023 : $signed(pct_lvl[10:0]);
    end else begin
      pct_tgt = (pct_lvl > 12'd1024) ? -11'sd1024 : $signed(11'(-pct_lvl));
    end
  end

  assign ramp_tgt = (req == pmrc_pkg::REQ_RAMP) ? val : pct_tgt;

  assign elapsed_inc = (elapsed_q == '1) ? elapsed_q
                                         : elapsed_q + pmrc_pkg::TIME_BITS'(1);

  // A tick that needs the interpolated level goes through the divider.
  assign ramp_step = (req == pmrc_pkg::REQ_TICK) && ramping_q && !timing_q &&
                     (elapsed_inc < span_q);

  assign diff     = 12'(target_q) - $signed({4'b0000, start_q});
  assign diff_mag = diff[11] ? 11'(-diff) : 11'(diff);

  // Floor division of a negative product rounds the magnitude up.
  assign step_mag = 12'(div_quo[10:0]) + 12'(div_stat.rem_nz && neg_q);
  assign step_lvl = $signed({5'b00000, start_q}) +
                    (neg_q ? $signed(-{1'b0, step_mag}) : $signed({1'b0, step_mag}));

  pmrc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_q),
    .divisor_i  (span_q),
    .stat_o     (div_stat),
    .quotient_o (div_quo)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      pmrc_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_d = ramp_step ? pmrc_pkg::ST_MUL : pmrc_pkg::ST_DONE;
        end
      end
      pmrc_pkg::ST_MUL:  state_d = pmrc_pkg::ST_LOAD;
      pmrc_pkg::ST_LOAD: state_d = pmrc_pkg::ST_DIV;
      pmrc_pkg::ST_DIV: begin
        if (div_stat.done) begin
          state_d = pmrc_pkg::ST_DONE;
        end
      end
      pmrc_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = pmrc_pkg::ST_IDLE;
        end
      end
      default: state_d = pmrc_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    s_axis_tready = 1'b0;
    div_start     = 1'b0;
    case (state_q)
      pmrc_pkg::ST_IDLE: s_axis_tready = 1'b1;
      pmrc_pkg::ST_LOAD: div_start     = 1'b1;
      default: begin
        s_axis_tready = 1'b0;
        div_start     = 1'b0;
      end
    endcase
  end

  // Controller state updates.
  always_comb begin
    level_d   = level_q;
    start_d   = start_q;
    target_d  = target_q;
    elapsed_d = elapsed_q;
    span_d    = span_q;
    ramping_d = ramping_q;
    timing_d  = timing_q;

    if (state_q == pmrc_pkg::ST_IDLE && in_fire) begin
      case (req)
        pmrc_pkg::REQ_SET_LEVEL: begin
          if (!val[10] && val[9:8] == 2'b00) begin
            level_d = val[7:0];
          end
        end
        pmrc_pkg::REQ_SET_PCT: begin
          if (!val[10] && val[9:0] <= 10'd100) begin
            level_d = pct_lvl[7:0];
          end
        end
        pmrc_pkg::REQ_ON, pmrc_pkg::REQ_OFF: begin
          if (stop) begin
            ramping_d = 1'b0;
            timing_d  = 1'b0;
          end
          level_d = (req == pmrc_pkg::REQ_ON) ? 8'hFF : 8'h00;
        end
        pmrc_pkg::REQ_TIMED_ON: begin
          ramping_d = 1'b0;
          timing_d  = 1'b1;
          elapsed_d = '0;
          span_d    = dur;
        end
        pmrc_pkg::REQ_RAMP, pmrc_pkg::REQ_RAMP_PCT: begin
          timing_d  = 1'b0;
          ramping_d = 1'b0;
          start_d   = level_q;
          target_d  = ramp_tgt;
          if (ramp_tgt != $signed({3'b000, level_q})) begin
            ramping_d = 1'b1;
            elapsed_d = '0;
            span_d    = dur;
          end
        end
        pmrc_pkg::REQ_TICK: begin
          if (timing_q || ramping_q) begin
            elapsed_d = elapsed_inc;
            if (timing_q) begin
              if (elapsed_inc < span_q) begin
                level_d = 8'hFF;
              end else begin
                timing_d  = 1'b0;
                ramping_d = 1'b0;
                level_d   = 8'h00;
              end
            end else if (!ramp_step) begin
              // Ramp has run its span: land on the target if it is a level.
              ramping_d = 1'b0;
              if (!target_q[10] && target_q[9:8] == 2'b00) begin
                level_d = target_q[7:0];
              end
            end
          end
        end
        default: level_d = level_q;
      endcase
    end else if (state_q == pmrc_pkg::ST_DIV && div_stat.done) begin
      if (!step_lvl[12] && step_lvl[11:8] == 4'b0000) begin
        level_d = step_lvl[7:0];
      end
    end
  end

  // Result register.
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (state_q == pmrc_pkg::ST_DONE && out_free) begin
      out_valid_d = 1'b1;
      out_data_d  = pmrc_pkg::OUT_DATA_W'({timing_q, ramping_q,
                                           pmrc_pkg::lvl_to_pct(level_q),
                                           (level_q != 8'h00), level_q});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pmrc_pkg::ST_IDLE;
      level_q     <= '0;
      start_q     <= '0;
      target_q    <= '0;
      elapsed_q   <= '0;
      span_q      <= '0;
      ramping_q   <= 1'b0;
      timing_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      level_q     <= level_d;
      start_q     <= start_d;
      target_q    <= target_d;
      elapsed_q   <= elapsed_d;
      span_q      <= span_d;
      ramping_q   <= ramping_d;
      timing_q    <= timing_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Product of elapsed ticks and the ramp height, taken once per ramp tick.
  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    if (state_q == pmrc_pkg::ST_MUL) begin
      prod_q <= pmrc_pkg::DIV_W'(elapsed_q) * pmrc_pkg::DIV_W'(diff_mag);
      neg_q  <= diff[11];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// File: rtl/pmrc_div.sv
module pmrc_div (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  input  logic [pmrc_pkg::DIV_W-1:0]             dividend_i,
  input  logic [pmrc_pkg::TIME_BITS-1:0]         divisor_i,
  output pmrc_pkg::div_stat_t                    stat_o,
  output logic [pmrc_pkg::DIV_W-1:0]             quotient_o
);

  logic                              busy_q, busy_d;
  logic                              done_q, done_d;
  logic [pmrc_pkg::DIV_CNT_W-1:0]    cnt_q, cnt_d;
  logic [pmrc_pkg::TIME_BITS-1:0]    rem_q, rem_d;
  logic [pmrc_pkg::TIME_BITS-1:0]    dvs_q, dvs_d;
  logic [pmrc_pkg::DIV_W-1:0]        quo_q, quo_d;
  logic [pmrc_pkg::TIME_BITS:0]      rem_sh;
  logic [pmrc_pkg::TIME_BITS:0]      rem_sub;

  // One restoring step per cycle, one quotient bit shifted in each time.
  always_comb begin
    rem_sh  = {rem_q, quo_q[pmrc_pkg::DIV_W-1]};
    rem_sub = rem_sh - {1'b0, dvs_q};
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    quo_d   = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dvs_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      if (!rem_sub[pmrc_pkg::TIME_BITS]) begin
        rem_d = rem_sub[pmrc_pkg::TIME_BITS-1:0];
        quo_d = {quo_q[pmrc_pkg::DIV_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[pmrc_pkg::TIME_BITS-1:0];
        quo_d = {quo_q[pmrc_pkg::DIV_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + pmrc_pkg::DIV_CNT_W'(1);
      if (cnt_q == pmrc_pkg::DIV_CNT_W'(pmrc_pkg::DIV_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign stat_o.done   = done_q;
  assign stat_o.rem_nz = (rem_q != '0);
  assign quotient_o    = quo_q;

endmodule

// File: rtl/pmrc_chk.sv
`include "assert_macros.svh"

module pmrc_chk (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [pmrc_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

  // A result offered but not taken is still offered next cycle.
  `ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

  // The controller works on one command at a time.
  `ASSERT_NXT(a_one_at_a_time, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)

  // Motor-on flag follows the level.
  `ASSERT_IMP(a_motor_on, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[8] == (m_axis_tdata[7:0] != 8'h00))

  // Ramp and timed-on are never active together.
  `ASSERT_IMP(a_modes_excl, clk_i, rst_ni, m_axis_tvalid, !(m_axis_tdata[16] && m_axis_tdata[17]))

  // Percent stays within 0..100.
  `ASSERT_IMP(a_pct_range, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[15:9] <= 7'd100)

endmodule

bind pwm_motor_ramp_controller_unit pmrc_chk u_pmrc_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
